### src/spcr_pkg.sv
// spcr_pkg: shared widths, shape codes and payload types for the shape pair
// collide/resolve pipeline. No dependencies.
`timescale 1ns / 1ps

package spcr_pkg;

  localparam int CW   = 24;          // position width
  localparam int SW   = CW - 2;      // size width
  localparam int MAGW = CW + 1;      // |b - a|
  localparam int SQW  = 2 * MAGW;    // squared distance
  localparam int RW   = MAGW;        // floor(sqrt)
  localparam int RSW  = SW + 1;      // radius sum, penetration
  localparam int NW   = MAGW + RSW;  // divider numerator
  localparam int DENW = RW + 1;      // divider denominator
  localparam int QW   = RSW;         // move magnitude
  localparam int TOLW = 8;

  localparam logic [TOLW-1:0] TOL_RESET = TOLW'(1);

  // mode bits
  localparam int MODE_LOCK = 0;
  localparam int MODE_TRIG = 1;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_BOX    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0]             a_kind;
    logic [1:0]             a_mode;
    logic signed [CW-1:0]   a_x;
    logic signed [CW-1:0]   a_y;
    logic [SW-1:0]          a_size_x;
    logic [SW-1:0]          a_size_y;
    logic [1:0]             b_kind;
    logic [1:0]             b_mode;
    logic signed [CW-1:0]   b_x;
    logic signed [CW-1:0]   b_y;
    logic [SW-1:0]          b_size_x;
    logic [SW-1:0]          b_size_y;
  } in_t;

  typedef struct packed {
    logic                   hit;
    logic signed [CW-1:0]   new_a_x;
    logic signed [CW-1:0]   new_a_y;
    logic signed [CW-1:0]   new_b_x;
    logic signed [CW-1:0]   new_b_y;
  } out_t;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
  } pos4_t;

  // front end -> square root sideband
  typedef struct packed {
    logic            hit;
    logic            cc;      // circle push
    logic            bp;      // box push
    logic            axis_y;
    logic            w2;      // mover takes the whole move
    logic            wa;      // a moves
    logic            wb;      // b moves
    logic            dirx;    // b moves toward +x
    logic            diry;
    logic [MAGW-1:0] adx;
    logic [MAGW-1:0] ady;
    logic [RSW-1:0]  rsum;
    logic [CW-1:0]   p2;      // doubled box depth on chosen axis
    pos4_t           pos;
  } fr_t;

  // sideband through the divider
  typedef struct packed {
    logic           hit;
    logic           cc;
    logic           bp;
    logic           axis_y;
    logic           zlen;     // coinciding centres
    logic [RSW-1:0] pen;
    logic [QW-1:0]  mb;       // box move magnitude
    logic           w2;
    logic           wa;
    logic           wb;
    logic           dirx;
    logic           diry;
    pos4_t          pos;
  } mid_t;

endpackage

### src/spcr_ifs.sv
// spcr_in_if / spcr_out_if: valid/ready word channels for shape pairs and results.
// Depends on spcr_pkg.
`timescale 1ns / 1ps

interface spcr_in_if;
  import spcr_pkg::*;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spcr_out_if;
  import spcr_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/spcr_front.sv
// spcr_front: three stages of distance, squares, overlap tests and push setup.
// Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  spcr_pkg::in_t             data_i,
  input  logic [spcr_pkg::TOLW-1:0] tol_i,
  output logic                      valid_o,
  output logic [spcr_pkg::SQW-1:0]  s_o,
  output spcr_pkg::fr_t             side_o
);
  import spcr_pkg::*;

  typedef enum logic [2:0] {
    PAIR_PP, PAIR_PC, PAIR_CC, PAIR_PB, PAIR_CB, PAIR_BB, PAIR_NONE
  } pair_e;

  // ---------------- stage 1 ----------------
  logic signed [MAGW-1:0] dx, dy;
  logic [MAGW-1:0] adx_d, ady_d;
  pair_e           pair_d;
  logic            bxa;
  logic [SW-1:0]   rc, bw_d, bh_d, ow, oh;
  logic [1:0]      okind;
  logic [RSW-1:0]  ox, oy, thr_d;
  logic [CW-1:0]   limx_d, limy_d;
  logic            solid, lock_a, lock_b;

  always_comb begin
    dx = MAGW'(data_i.b_x) - MAGW'(data_i.a_x);
    dy = MAGW'(data_i.b_y) - MAGW'(data_i.a_y);
    adx_d = dx[MAGW-1] ? MAGW'(-dx) : MAGW'(dx);
    ady_d = dy[MAGW-1] ? MAGW'(-dy) : MAGW'(dy);

    unique case ({data_i.a_kind, data_i.b_kind})
      {KIND_POINT, KIND_POINT}:   pair_d = PAIR_PP;
      {KIND_POINT, KIND_CIRCLE},
      {KIND_CIRCLE, KIND_POINT}:  pair_d = PAIR_PC;
      {KIND_CIRCLE, KIND_CIRCLE}: pair_d = PAIR_CC;
      {KIND_POINT, KIND_BOX},
      {KIND_BOX, KIND_POINT}:     pair_d = PAIR_PB;
      {KIND_CIRCLE, KIND_BOX},
      {KIND_BOX, KIND_CIRCLE}:    pair_d = PAIR_CB;
      {KIND_BOX, KIND_BOX}:       pair_d = PAIR_BB;
      default:                    pair_d = PAIR_NONE;
    endcase

    rc    = (data_i.a_kind == KIND_CIRCLE) ? data_i.a_size_x : data_i.b_size_x;
    // box is a only when b is not a box
    bxa   = (data_i.a_kind == KIND_BOX) && (data_i.b_kind != KIND_BOX);
    bw_d  = bxa ? data_i.a_size_x : data_i.b_size_x;
    bh_d  = bxa ? data_i.a_size_y : data_i.b_size_y;
    ow    = bxa ? data_i.b_size_x : data_i.a_size_x;
    oh    = bxa ? data_i.b_size_y : data_i.a_size_y;
    okind = bxa ? data_i.b_kind : data_i.a_kind;
    ox    = (okind == KIND_CIRCLE) ? {ow, 1'b0} : {1'b0, ow};
    oy    = (okind == KIND_CIRCLE) ? {ow, 1'b0} : {1'b0, oh};

    if (pair_d == PAIR_PB) begin
      limx_d = CW'(bw_d);
      limy_d = CW'(bh_d);
    end else begin
      limx_d = CW'(bw_d) + CW'(ox);
      limy_d = CW'(bh_d) + CW'(oy);
    end

    unique case (pair_d)
      PAIR_PP: thr_d = RSW'(tol_i);
      PAIR_PC: thr_d = RSW'(rc);
      PAIR_CC: thr_d = RSW'(data_i.a_size_x) + RSW'(data_i.b_size_x);
      default: thr_d = '0;
    endcase

    lock_a = data_i.a_mode[MODE_LOCK];
    lock_b = data_i.b_mode[MODE_LOCK];
    solid  = !(data_i.a_mode[MODE_TRIG] || data_i.b_mode[MODE_TRIG]) && !(lock_a && lock_b);
  end

  logic            v1_q;
  pair_e           pair1_q;
  logic [MAGW-1:0] adx1_q, ady1_q;
  logic            dxn1_q, dyn1_q, dxz1_q, dyz1_q;
  logic [RSW-1:0]  thr1_q;
  logic [CW-1:0]   limx1_q, limy1_q;
  logic [SW-1:0]   bw1_q, bh1_q;
  logic            solid1_q, wa1_q, wb1_q, w21_q;
  pos4_t           pos1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair1_q  <= pair_d;
      adx1_q   <= adx_d;
      ady1_q   <= ady_d;
      dxn1_q   <= dx[MAGW-1];
      dyn1_q   <= dy[MAGW-1];
      dxz1_q   <= (dx == '0);
      dyz1_q   <= (dy == '0);
      thr1_q   <= thr_d;
      limx1_q  <= limx_d;
      limy1_q  <= limy_d;
      bw1_q    <= bw_d;
      bh1_q    <= bh_d;
      solid1_q <= solid;
      wa1_q    <= !lock_a;
      wb1_q    <= !lock_b;
      w21_q    <= lock_a || lock_b;
      pos1_q   <= '{ax: data_i.a_x, ay: data_i.a_y, bx: data_i.b_x, by: data_i.b_y};
    end
  end

  // ---------------- stage 2 ----------------
  logic [MAGW:0]   tw_x, tw_y;
  logic [CW-1:0]   p2x_d, p2y_d;

  always_comb begin
    tw_x  = {adx1_q, 1'b0};
    tw_y  = {ady1_q, 1'b0};
    p2x_d = ((MAGW+1)'(limx1_q) > tw_x) ? CW'((MAGW+1)'(limx1_q) - tw_x) : '0;
    p2y_d = ((MAGW+1)'(limy1_q) > tw_y) ? CW'((MAGW+1)'(limy1_q) - tw_y) : '0;
  end

  logic               v2_q;
  pair_e              pair2_q;
  logic [SQW-1:0]     sqx2_q, sqy2_q;
  logic [2*RSW-1:0]   thsq2_q;
  logic [MAGW+SW-1:0] sl1_q, sl2_q;
  logic               bhit2_q, dxz2_q, dyz2_q, dirx2_q, diry2_q;
  logic [CW-1:0]      p2x2_q, p2y2_q;
  logic [RSW-1:0]     rsum2_q;
  logic [MAGW-1:0]    adx2_q, ady2_q;
  logic               solid2_q, wa2_q, wb2_q, w22_q;
  pos4_t              pos2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pair2_q  <= pair1_q;
      sqx2_q   <= SQW'(adx1_q) * SQW'(adx1_q);
      sqy2_q   <= SQW'(ady1_q) * SQW'(ady1_q);
      thsq2_q  <= (2*RSW)'(thr1_q) * (2*RSW)'(thr1_q);
      sl1_q    <= (MAGW+SW)'(ady1_q) * (MAGW+SW)'(bw1_q);
      sl2_q    <= (MAGW+SW)'(adx1_q) * (MAGW+SW)'(bh1_q);
      bhit2_q  <= (tw_x < (MAGW+1)'(limx1_q)) && (tw_y < (MAGW+1)'(limy1_q));
      dxz2_q   <= dxz1_q;
      dyz2_q   <= dyz1_q;
      dirx2_q  <= !dxn1_q;
      diry2_q  <= !dyn1_q;
      p2x2_q   <= p2x_d;
      p2y2_q   <= p2y_d;
      rsum2_q  <= thr1_q;
      adx2_q   <= adx1_q;
      ady2_q   <= ady1_q;
      solid2_q <= solid1_q;
      wa2_q    <= wa1_q;
      wb2_q    <= wb1_q;
      w22_q    <= w21_q;
      pos2_q   <= pos1_q;
    end
  end

  // ---------------- stage 3 ----------------
  logic [SQW-1:0] s_d;
  logic           hit_d, selx, sely;
  fr_t            side_d;

  always_comb begin
    s_d = sqx2_q + sqy2_q;
    unique case (pair2_q)
      PAIR_PP, PAIR_PC, PAIR_CC: hit_d = (s_d < SQW'(thsq2_q));
      PAIR_PB, PAIR_CB, PAIR_BB: hit_d = bhit2_q;
      default:                   hit_d = 1'b0;
    endcase
    // exit side: x when its slope wins or ties, else y; none at zero offset
    selx = !dxz2_q && (sl1_q <= sl2_q);
    sely = !dyz2_q && (sl2_q <= sl1_q);

    side_d        = '0;
    side_d.hit    = hit_d;
    side_d.cc     = hit_d && solid2_q && (pair2_q == PAIR_CC);
    side_d.bp     = hit_d && solid2_q && (selx || sely) &&
                    ((pair2_q == PAIR_CB) || (pair2_q == PAIR_BB));
    side_d.axis_y = !selx;
    side_d.w2     = w22_q;
    side_d.wa     = wa2_q;
    side_d.wb     = wb2_q;
    side_d.dirx   = dirx2_q;
    side_d.diry   = diry2_q;
    side_d.adx    = adx2_q;
    side_d.ady    = ady2_q;
    side_d.rsum   = rsum2_q;
    side_d.p2     = selx ? p2x2_q : p2y2_q;
    side_d.pos    = pos2_q;
  end

  logic           v3_q;
  logic [SQW-1:0] s3_q;
  fr_t            side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q    <= s_d;
      side3_q <= side_d;
    end
  end

  assign valid_o = v3_q;
  assign s_o     = s3_q;
  assign side_o  = side3_q;

endmodule

### src/spcr_isqrt.sv
// spcr_isqrt: pipelined integer square root, one root bit per stage.
// Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_isqrt #(
  parameter type side_t = logic
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [spcr_pkg::SQW-1:0] rad_i,
  input  side_t                    side_i,
  output logic                     valid_o,
  output logic [spcr_pkg::RW-1:0]  root_o,
  output side_t                    side_o
);
  import spcr_pkg::*;

  logic [RW-1:0]   v_q;
  logic [SQW-1:0]  rad_q  [RW-1];
  logic [RW+1:0]   rem_q  [RW-1];
  logic [RW-1:0]   root_q [RW];
  side_t           side_q [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SQW-1:0] rad_in;
    logic [RW+1:0]  rem_in;
    logic [RW-1:0]  root_in;
    side_t          side_in;
    logic           v_in;
    logic [RW+3:0]  rem_sh, trial;
    logic           ge;
    logic [RW+1:0]  rem_nx;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, rad_in[SQW-1 -: 2]};
      trial  = (RW+4)'({root_in, 2'b01});
      ge     = (rem_sh >= trial);
      rem_nx = ge ? (RW+2)'(rem_sh - trial) : (RW+2)'(rem_sh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_in[RW-2:0], ge};
        side_q[k] <= side_in;
      end
    end

    if (k < RW - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= rem_nx;
          rad_q[k] <= {rad_in[SQW-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

### src/spcr_div.sv
// spcr_div: two-lane pipelined restoring divider with a shared divisor and
// round-half-up quotients. Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_div #(
  parameter type side_t = logic
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [spcr_pkg::NW-1:0]   numx_i,
  input  logic [spcr_pkg::NW-1:0]   numy_i,
  input  logic [spcr_pkg::DENW-1:0] den_i,
  input  side_t                     side_i,
  output logic                      valid_o,
  output logic [spcr_pkg::QW-1:0]   qx_o,
  output logic [spcr_pkg::QW-1:0]   qy_o,
  output side_t                     side_o
);
  import spcr_pkg::*;

  logic [QW-1:0]   v_q;
  logic [NW-1:0]   rx_q  [QW];
  logic [NW-1:0]   ry_q  [QW];
  logic [QW-1:0]   qx_q  [QW];
  logic [QW-1:0]   qy_q  [QW];
  logic [DENW-1:0] den_q [QW];
  side_t           side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NW-1:0]   rx_in, ry_in, dsh;
    logic [QW-1:0]   qx_in, qy_in;
    logic [DENW-1:0] den_in;
    side_t           side_in;
    logic            v_in, gex, gey;

    if (k == 0) begin : g_first
      assign rx_in   = numx_i;
      assign ry_in   = numy_i;
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rx_in   = rx_q[k-1];
      assign ry_in   = ry_q[k-1];
      assign qx_in   = qx_q[k-1];
      assign qy_in   = qy_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign v_in    = v_q[k-1];
    end

    always_comb begin
      dsh = NW'(den_in) << SH;
      gex = (rx_in >= dsh);
      gey = (ry_in >= dsh);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k]   <= gex ? rx_in - dsh : rx_in;
        ry_q[k]   <= gey ? ry_in - dsh : ry_in;
        qx_q[k]   <= QW'({qx_in, gex});
        qy_q[k]   <= QW'({qy_in, gey});
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  // round half up: bump when twice the remainder reaches the divisor
  logic rndx, rndy;
  always_comb begin
    rndx = ({1'b0, rx_q[QW-1]} << 1) >= (NW+1)'(den_q[QW-1]);
    rndy = ({1'b0, ry_q[QW-1]} << 1) >= (NW+1)'(den_q[QW-1]);
  end

  assign valid_o = v_q[QW-1];
  assign qx_o    = qx_q[QW-1] + QW'(rndx);
  assign qy_o    = qy_q[QW-1] + QW'(rndy);
  assign side_o  = side_q[QW-1];

endmodule

### src/shape_pair_collide_resolve.sv
// shape_pair_collide_resolve: top level of the shape pair overlap test and push-out.
// Depends on spcr_pkg, spcr_ifs, spcr_front, spcr_isqrt, spcr_div.
`timescale 1ns / 1ps

// Takes one shape pair word per clock while the output side keeps up and returns
// one result word per pair, in order. The pipe is a chain of three front-end stages
// (offset, squares and slope products, overlap and exit side), a 25-stage square
// root that yields one root bit per stage, two setup stages (penetration, then the
// offset-times-penetration products), a 23-stage divider yielding one quotient bit
// per stage for both axes at once, one stage that picks the move magnitudes and the
// output register that applies and saturates them. Every stage advances on one
// shared enable, so the sustained rate is one pair per cycle; a stalled output
// register freezes the whole pipe and in_i.ready drops in the same cycle. The user
// must write point_tolerance through cfg_we_i/cfg_wdata_i only while no pair is in
// flight; the block does not enforce this. No clearing pass after reset.
module shape_pair_collide_resolve (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  spcr_in_if.sink                   in_i,
  spcr_out_if.source                out_o,
  input  logic                      cfg_we_i,
  input  logic [spcr_pkg::TOLW-1:0] cfg_wdata_i
);
  import spcr_pkg::*;

  // ---------------- control ----------------
  logic out_valid_q;
  out_t out_data_q;
  logic en;

  // whole pipe moves unless a finished word is held at the output
  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  logic [TOLW-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // ---------------- front end ----------------
  logic           f_valid;
  logic [SQW-1:0] f_s;
  fr_t            f_side;

  spcr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .tol_i   (tol_q),
    .valid_o (f_valid),
    .s_o     (f_s),
    .side_o  (f_side)
  );

  // ---------------- centre distance ----------------
  logic          q_valid;
  logic [RW-1:0] q_len;
  fr_t           q_side;

  spcr_isqrt #(.side_t(fr_t)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .rad_i   (f_s),
    .side_i  (f_side),
    .valid_o (q_valid),
    .root_o  (q_len),
    .side_o  (q_side)
  );

  // ---------------- penetration and box move ----------------
  // len < radius sum whenever circles overlap, so the cut to RSW is safe there
  logic [CW:0] bpw;
  mid_t        p_mid_d;

  always_comb begin
    bpw = q_side.w2 ? {q_side.p2, 1'b0} : {1'b0, q_side.p2};
    bpw = bpw + (CW+1)'(2);
    p_mid_d        = '0;
    p_mid_d.hit    = q_side.hit;
    p_mid_d.cc     = q_side.cc;
    p_mid_d.bp     = q_side.bp;
    p_mid_d.axis_y = q_side.axis_y;
    p_mid_d.zlen   = (q_len == '0);
    p_mid_d.pen    = q_side.rsum - RSW'(q_len);
    p_mid_d.mb     = QW'(bpw[CW:2]);     // p2*weight/4 = depth*weight/2, rounded
    p_mid_d.w2     = q_side.w2;
    p_mid_d.wa     = q_side.wa;
    p_mid_d.wb     = q_side.wb;
    p_mid_d.dirx   = q_side.dirx;
    p_mid_d.diry   = q_side.diry;
    p_mid_d.pos    = q_side.pos;
  end

  logic            p_valid_q;
  mid_t            p_mid_q;
  logic [RW-1:0]   p_len_q;
  logic [MAGW-1:0] p_adx_q, p_ady_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_mid_q <= p_mid_d;
      p_len_q <= q_len;
      p_adx_q <= q_side.adx;
      p_ady_q <= q_side.ady;
    end
  end

  // ---------------- divider operands ----------------
  // whole move: divide by len; half move: by 2*len
  logic            m_valid_q;
  mid_t            m_mid_q;
  logic [NW-1:0]   m_nx_q, m_ny_q;
  logic [DENW-1:0] m_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mid_q <= p_mid_q;
      m_nx_q  <= NW'(p_adx_q) * NW'(p_mid_q.pen);
      m_ny_q  <= NW'(p_ady_q) * NW'(p_mid_q.pen);
      m_den_q <= p_mid_q.w2 ? {1'b0, p_len_q} : {p_len_q, 1'b0};
    end
  end

  logic          d_valid;
  logic [QW-1:0] d_qx, d_qy;
  mid_t          d_mid;

  spcr_div #(.side_t(mid_t)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (m_valid_q),
    .numx_i  (m_nx_q),
    .numy_i  (m_ny_q),
    .den_i   (m_den_q),
    .side_i  (m_mid_q),
    .valid_o (d_valid),
    .qx_o    (d_qx),
    .qy_o    (d_qy),
    .side_o  (d_mid)
  );

  // ---------------- move selection ----------------
  logic [RSW:0]  cz;
  logic [QW-1:0] mx_d, my_d;

  always_comb begin
    // coinciding centres: push along +y by pen*weight/2, rounded
    cz = d_mid.w2 ? {d_mid.pen, 1'b0} : {1'b0, d_mid.pen};
    cz = cz + (RSW+1)'(1);
    mx_d = '0;
    my_d = '0;
    if (d_mid.cc) begin
      if (d_mid.zlen) begin
        my_d = QW'(cz[RSW:1]);
      end else begin
        mx_d = d_qx;
        my_d = d_qy;
      end
    end else if (d_mid.bp) begin
      if (d_mid.axis_y) begin
        my_d = d_mid.mb;
      end else begin
        mx_d = d_mid.mb;
      end
    end
  end

  logic          r_valid_q;
  logic [QW-1:0] r_mx_q, r_my_q;
  mid_t          r_mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
    end else if (en) begin
      r_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_mx_q  <= mx_d;
      r_my_q  <= my_d;
      r_mid_q <= d_mid;
    end
  end

  // ---------------- apply and saturate ----------------
  function automatic logic signed [CW-1:0] move_sat(logic signed [CW-1:0] p,
                                                    logic [QW-1:0] m, logic neg);
    logic signed [CW+1:0] mv;
    logic signed [CW+1:0] sum;
    logic                 ovf;
    mv  = $signed((CW+2)'(m));
    if (neg) begin
      mv = -mv;
    end
    sum = (CW+2)'(p) + mv;
    ovf = (sum[CW+1:CW-1] != '0) && (sum[CW+1:CW-1] != '1);
    if (ovf) begin
      return sum[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return sum[CW-1:0];
  endfunction

  // b moves along its direction bits, a the opposite way
  out_t          out_d;
  logic [QW-1:0] ma_x, ma_y, mb_x, mb_y;

  always_comb begin
    ma_x = r_mid_q.wa ? r_mx_q : '0;
    ma_y = r_mid_q.wa ? r_my_q : '0;
    mb_x = r_mid_q.wb ? r_mx_q : '0;
    mb_y = r_mid_q.wb ? r_my_q : '0;
    out_d.hit     = r_mid_q.hit;
    out_d.new_a_x = move_sat(r_mid_q.pos.ax, ma_x, r_mid_q.dirx);
    out_d.new_a_y = move_sat(r_mid_q.pos.ay, ma_y, r_mid_q.diry);
    out_d.new_b_x = move_sat(r_mid_q.pos.bx, mb_x, !r_mid_q.dirx);
    out_d.new_b_y = move_sat(r_mid_q.pos.by, mb_y, !r_mid_q.diry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // a held result must freeze intake
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while output word is held");

  // no move without an overlap
  a_move_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && !r_mid_q.hit) |-> (r_mx_q == '0 && r_my_q == '0))
    else $error("push-out on a non-overlapping pair");

  // circle and box push are exclusive
  a_push_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid |-> !(d_mid.cc && d_mid.bp))
    else $error("circle and box push both set");

  // frozen pipe keeps its occupancy
  a_freeze_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(p_valid_q) && $stable(r_valid_q)))
    else $error("pipeline moved while stalled");
`endif

endmodule
